// ===== rtl/dqu_pkg.sv =====
// Shared types and constants for the double-ended queue unit.
package dqu_pkg;

    localparam int unsigned DEPTH_DEF  = 16;
    localparam int unsigned DATA_W     = 32;
    localparam int unsigned CMD_W      = 3;
    localparam int unsigned LEVEL_W    = 5;
    localparam int unsigned IN_TDATA_W = 40;   // 3 + 32 = 35, padded to 5 bytes
    localparam int unsigned OUT_TDATA_W = 72;  // 32 + 32 + 1 + 1 + 5 + 1 = 72

    localparam logic [DATA_W-1:0] EMPTY_MARK = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_NONE       = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_PUSH_REAR  = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_POP_REAR   = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD
    } t_state;

endpackage

// ===== rtl/dqu_ram.sv =====
// Slot memory: one write port, two registered read ports.
module dqu_ram import dqu_pkg::*; #(
    parameter int unsigned DEPTH = DEPTH_DEF,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr_a,
    input  logic [AW-1:0]     i_raddr_b,
    output logic [DATA_W-1:0] o_rdata_a,
    output logic [DATA_W-1:0] o_rdata_b
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rdata_a;
    logic [DATA_W-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= mem[i_raddr_a];
            r_rdata_b <= mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== rtl/dqu_ptr.sv =====
// Front/rear ring pointers, fill count and slot write request per command.
module dqu_ptr import dqu_pkg::*; #(
    parameter int unsigned DEPTH = DEPTH_DEF,
    parameter int unsigned AW    = $clog2(DEPTH),
    parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [CMD_W-1:0]  i_cmd,
    input  logic [DATA_W-1:0] i_value,
    output logic              o_we,
    output logic [AW-1:0]     o_waddr,
    output logic [DATA_W-1:0] o_wdata,
    output logic [AW-1:0]     o_front,
    output logic [AW-1:0]     o_rear,
    output logic [CW-1:0]     o_count,
    output logic              o_rejected
);

    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_CNT  = CW'(1);

    logic [AW-1:0] r_front, n_front;
    logic [AW-1:0] r_rear,  n_rear;
    logic [CW-1:0] r_count, n_count;
    logic          r_rejected, n_rejected;

    logic [AW-1:0] w_front_prev;
    logic [AW-1:0] w_rear_next;
    logic [AW-1:0] w_rear_prev;
    logic [AW-1:0] w_front_next;
    logic          w_full;
    logic          w_empty;
    t_cmd          w_cmd;

    assign w_cmd        = t_cmd'(i_cmd);
    assign w_full       = (r_count == FULL_CNT);
    assign w_empty      = (r_count == '0);
    assign w_front_prev = (r_front == '0) ? LAST_IDX : r_front - AW'(1);
    assign w_front_next = (r_front == LAST_IDX) ? '0 : r_front + AW'(1);
    assign w_rear_prev  = (r_rear == '0) ? LAST_IDX : r_rear - AW'(1);
    assign w_rear_next  = (r_rear == LAST_IDX) ? '0 : r_rear + AW'(1);

    always_comb begin
        n_front    = r_front;
        n_rear     = r_rear;
        n_count    = r_count;
        n_rejected = 1'b0;
        o_we       = 1'b0;
        o_waddr    = r_front;
        unique case (w_cmd)
            CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
                if (w_full) begin
                    n_rejected = 1'b1;
                end else if (w_empty) begin
                    // first element sits at the front slot; rear joins it
                    o_we    = 1'b1;
                    o_waddr = r_front;
                    n_rear  = r_front;
                    n_count = ONE_CNT;
                end else if (w_cmd == CMD_PUSH_FRONT) begin
                    o_we    = 1'b1;
                    o_waddr = w_front_prev;
                    n_front = w_front_prev;
                    n_count = r_count + ONE_CNT;
                end else begin
                    o_we    = 1'b1;
                    o_waddr = w_rear_next;
                    n_rear  = w_rear_next;
                    n_count = r_count + ONE_CNT;
                end
            end
            CMD_POP_FRONT, CMD_POP_REAR: begin
                if (r_count == ONE_CNT) begin
                    n_rear  = r_front;
                    n_count = '0;
                end else if (!w_empty) begin
                    if (w_cmd == CMD_POP_FRONT) begin
                        n_front = w_front_next;
                    end else begin
                        n_rear = w_rear_prev;
                    end
                    n_count = r_count - ONE_CNT;
                end
            end
            default: begin
                // no-op and unused codes
            end
        endcase
        o_we = o_we & i_accept;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front    <= '0;
            r_rear     <= '0;
            r_count    <= '0;
            r_rejected <= 1'b0;
        end else if (i_accept) begin
            r_front    <= n_front;
            r_rear     <= n_rear;
            r_count    <= n_count;
            r_rejected <= n_rejected;
        end
    end

    assign o_wdata    = i_value;
    assign o_front    = r_front;
    assign o_rear     = r_rear;
    assign o_count    = r_count;
    assign o_rejected = r_rejected;

endmodule

// ===== rtl/double_ended_queue_unit.sv =====
// Top level of the double-ended queue unit: sequencer, output register, memory and pointers.
//
// Bounded deque of signed 32-bit values held in a DEPTH-slot ring memory.
// Input channel s_axis: one beat is one command (none, push front, push
// rear, pop front, pop rear) plus the value to push. Output channel m_axis:
// exactly one beat per command with the front and rear values after the
// command (all ones when empty), empty/full flags, fill level and a reject
// flag for a push into a full queue.
// The slot memory has one write port and registered read data, so each
// command goes through a write and pointer step, a read of the front and
// rear slots, and a load of the output register, in that order. A new
// command is taken only after the previous one has been loaded into the
// output register.
// Reset (i_rst_n low, synchronous) empties the queue and drops any pending
// result; slot contents are not cleared and an empty queue reports all ones.
// When the receiver stalls, the finished beat waits in the output register
// while the next command is still taken; that command's result then waits
// in the read-data register until the output register frees up, and no
// further command is taken meanwhile.
module double_ended_queue_unit import dqu_pkg::*; #(
    parameter int unsigned DEPTH = DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [2:0] cmd, [34:3] value, [39:35] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [31:0] front_value, [63:32] rear_value, [64] queue_empty, [65] is_full,
    // [70:66] fill_level, [71] rejected
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_state r_state, n_state;
    logic   w_accept;
    logic   w_read;
    logic   w_load;

    logic                   w_we;
    logic [AW-1:0]          w_waddr;
    logic [DATA_W-1:0]      w_wdata;
    logic [AW-1:0]          w_front;
    logic [AW-1:0]          w_rear;
    logic [CW-1:0]          w_count;
    logic                   w_rejected;
    logic [DATA_W-1:0]      w_rdata_front;
    logic [DATA_W-1:0]      w_rdata_rear;

    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic [OUT_TDATA_W-1:0] w_out_data;
    logic                   w_empty;

    assign w_accept = s_axis_tvalid & s_axis_tready;

    dqu_ptr #(
        .DEPTH (DEPTH)
    ) u_ptr (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_cmd      (s_axis_tdata[CMD_W-1:0]),
        .i_value    (s_axis_tdata[CMD_W+DATA_W-1:CMD_W]),
        .o_we       (w_we),
        .o_waddr    (w_waddr),
        .o_wdata    (w_wdata),
        .o_front    (w_front),
        .o_rear     (w_rear),
        .o_count    (w_count),
        .o_rejected (w_rejected)
    );

    // Reads run the cycle after the write, so no same-slot bypass is needed.
    dqu_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_re      (w_read),
        .i_raddr_a (w_front),
        .i_raddr_b (w_rear),
        .o_rdata_a (w_rdata_front),
        .o_rdata_b (w_rdata_rear)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        w_read        = 1'b0;
        w_load        = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                w_read  = 1'b1;
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                // hold until the output register is free or draining
                if (!r_out_valid || m_axis_tready) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign w_empty = (w_count == '0);

    always_comb begin
        w_out_data         = '0;
        w_out_data[31:0]   = w_empty ? EMPTY_MARK : w_rdata_front;
        w_out_data[63:32]  = w_empty ? EMPTY_MARK : w_rdata_rear;
        w_out_data[64]     = w_empty;
        w_out_data[65]     = (w_count == FULL_CNT);
        w_out_data[70:66]  = LEVEL_W'(w_count);
        w_out_data[71]     = w_rejected;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data <= w_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Fill count never exceeds the ring size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= FULL_CNT)
        else $error("fill count above DEPTH");

    // A taken command always moves the sequencer into the read cycle.
    a_accept_to_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_READ))
        else $error("command taken without slot read");

    // A loaded result shows up on the output the next cycle.
    a_load_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> r_out_valid)
        else $error("loaded result not presented");

    // An empty result carries the all-ones marker on both values.
    a_empty_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[64]) |->
            (r_out_data[31:0] == EMPTY_MARK && r_out_data[63:32] == EMPTY_MARK))
        else $error("empty result with stale values");

endmodule
